### src/fvc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fvc_pkg
// Shared types, codes and sizes of the frequency vote combiner.
// ----------------------------------------------------------------------------
package fvc_pkg;

   localparam int MAX_GOVERNORS = 8;
   localparam int NUM_POLICIES  = 8;

   // fixed field widths
   localparam int FREQ_W   = 32;
   localparam int FUNC_W   = 2;
   localparam int POL_W    = 3;
   localparam int GOV_W    = 3;
   localparam int MODE_W   = 2;
   localparam int NGOV_W   = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 4;

   // derived sizes
   localparam int GOV_CNT_W  = $clog2(MAX_GOVERNORS + 1);
   localparam int SUM_W      = FREQ_W + GOV_CNT_W;
   localparam int DIV_CNT_W  = $clog2(SUM_W + 1);
   localparam int VT_ADDR_W  = GOV_W + POL_W;
   localparam int VT_DEPTH   = 2 ** VT_ADDR_W;

   localparam int REQ_DATA_W = 112;
   localparam int RSP_DATA_W = 40;

   // item kinds
   localparam logic [FUNC_W-1:0] FUNC_VOTE   = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_MODE   = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_LIMITS = 2'd2;

   // combining modes
   localparam logic [MODE_W-1:0] MODE_MAX = 2'd0;
   localparam logic [MODE_W-1:0] MODE_MIN = 2'd1;
   localparam logic [MODE_W-1:0] MODE_AVG = 2'd2;
   localparam logic [MODE_W-1:0] MODE_BAD = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_GOV  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEF_MODE = 2'd1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_APPLY,
      ST_SCAN,
      ST_DIV,
      ST_DONE
   } state_type;

endpackage
`default_nettype wire

### src/frequency_vote_combiner.sv
`default_nettype none
// ----------------------------------------------------------------------------
// frequency_vote_combiner
// Per-policy combining of governor frequency votes with min/max clamping.
// ----------------------------------------------------------------------------
// Usage: items arrive on the req_ stream (kind in req_tuser) and each one
// produces exactly one beat on the rsp_ stream. The csr_ channel writes the
// enabled governor count (index 0) and the mode loaded into every policy
// (index 1); it is always ready, and the user must write it only while the
// block is idle; the block itself does not enforce this. One item is in
// flight at a time. After acceptance the APPLY state applies the update,
// then the votes of the n enabled governors are read from the vote memory
// one per cycle through its registered read port, and average mode adds a
// bit-serial divide of the SUM_W = 36 bit sum. A pass-through or error item
// skips the scan and the divide; the next item can be accepted in the cycle
// after the result loads. The result sits in an output register, so the next
// item is accepted while it waits; if rsp_tready stays low the following
// result holds in the final state until the register frees up.
// Reset clears the vote valid bits (every vote reads as zero), modes to max,
// limits to 0 and all ones, and the governor count to 2; no clearing pass.
// ----------------------------------------------------------------------------
module frequency_vote_combiner
   import fvc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,

   input  wire logic                  req_tvalid,
   output      logic                  req_tready,
   // policy_index[2:0], governor_index[5:3], freq_vote[37:6], vote_relation[38],
   // new_mode[40:39], limit_low[72:41], limit_high[104:73], zero pad
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // func[1:0]
   input  wire logic [FUNC_W-1:0]     req_tuser,

   output      logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   // out_policy[2:0], target_khz[34:3], out_relation[35], zero pad
   output      logic [RSP_DATA_W-1:0] rsp_tdata,
   // passed_through[0], error_flag[1]
   output      logic [1:0]            rsp_tuser,

   input  wire logic                  csr_valid,
   output      logic                  csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   state_type state_ff, state_in;

   // captured item
   logic [FUNC_W-1:0] it_func_ff;
   logic [POL_W-1:0]  it_pol_ff;
   logic [GOV_W-1:0]  it_gov_ff;
   logic [FREQ_W-1:0] it_vote_ff;
   logic              it_vrel_ff;
   logic [MODE_W-1:0] it_mode_ff;
   logic [FREQ_W-1:0] it_lo_ff;
   logic [FREQ_W-1:0] it_hi_ff;

   // policy state
   logic [NGOV_W-1:0] num_gov_ff;
   logic [MODE_W-1:0] pol_mode_ff [NUM_POLICIES];
   logic [FREQ_W-1:0] pol_lo_ff   [NUM_POLICIES];
   logic [FREQ_W-1:0] pol_hi_ff   [NUM_POLICIES];

   // vote memory
   logic [FREQ_W-1:0]   vote_mem [VT_DEPTH];
   logic [VT_DEPTH-1:0] vt_valid_ff;
   logic [FREQ_W-1:0]   ram_q_ff;
   logic                rd_valid_ff;
   logic                ram_we, ram_re;
   logic [VT_ADDR_W-1:0] ram_waddr, ram_raddr;

   // scan and divide
   logic [GOV_CNT_W-1:0] issue_ff;
   logic                 pend_ff;
   logic [MODE_W-1:0]    cur_mode_ff;
   logic [SUM_W-1:0]     acc_ff;
   logic [SUM_W-1:0]     div_q_ff;
   logic [GOV_CNT_W-1:0] rem_ff;
   logic [DIV_CNT_W-1:0] div_cnt_ff;

   // result register
   logic              rsp_valid_ff;
   logic [POL_W-1:0]  rsp_pol_ff;
   logic [FREQ_W-1:0] rsp_target_ff;
   logic              rsp_rel_ff;
   logic              rsp_pass_ff;
   logic              rsp_err_ff;

   logic [GOV_CNT_W-1:0] gov_cnt;
   logic                 pol_ok, gov_known, mode_bad, do_scan;
   logic [MODE_W-1:0]    eff_mode;
   logic                 scan_issue, scan_end, div_last, rsp_load;
   logic [FREQ_W-1:0]    vote_rd, acc_lo, comb_t, clamp_hi, clamp_t;
   logic [GOV_CNT_W:0]   div_sh;
   logic                 div_ge;
   logic [FREQ_W-1:0]    res_target;
   logic                 res_rel, res_pass, res_err;

   // ---------------------------------------------------------------- decode
   always_comb begin
      if (32'(num_gov_ff) > MAX_GOVERNORS) begin
         gov_cnt = GOV_CNT_W'(MAX_GOVERNORS);
      end else begin
         gov_cnt = GOV_CNT_W'(num_gov_ff);
      end
   end

   assign pol_ok    = 32'(it_pol_ff) < NUM_POLICIES;
   assign gov_known = 32'(it_gov_ff) < 32'(gov_cnt);
   assign mode_bad  = it_mode_ff == MODE_BAD;
   assign eff_mode  = (it_func_ff == FUNC_MODE) ? it_mode_ff : pol_mode_ff[it_pol_ff];
   assign do_scan   = pol_ok && !((it_func_ff == FUNC_VOTE) && !gov_known)
                      && !((it_func_ff == FUNC_MODE) && mode_bad);

   assign scan_end  = (issue_ff == gov_cnt) && !pend_ff;
   assign div_last  = div_cnt_ff == DIV_CNT_W'(SUM_W - 1);
   assign rsp_load  = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready);

   // ------------------------------------------------------------ next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_APPLY;
         end
         ST_APPLY: begin
            state_in = do_scan ? ST_SCAN : ST_DONE;
         end
         ST_SCAN: begin
            if (scan_end) begin
               if ((cur_mode_ff == MODE_AVG) && (gov_cnt != '0)) begin
                  state_in = ST_DIV;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DIV: begin
            if (div_last) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_load) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // --------------------------------------------------------------- outputs
   always_comb begin
      req_tready = 1'b0;
      scan_issue = 1'b0;
      ram_we     = 1'b0;
      case (state_ff)
         ST_IDLE:  req_tready = 1'b1;
         ST_APPLY: ram_we     = pol_ok && (it_func_ff == FUNC_VOTE) && gov_known;
         ST_SCAN:  scan_issue = issue_ff < gov_cnt;
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   assign ram_re    = scan_issue;
   assign ram_waddr = {it_gov_ff, it_pol_ff};
   assign ram_raddr = {issue_ff[GOV_W-1:0], it_pol_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // --------------------------------------------------------- vote memory
   always_ff @(posedge clock) begin
      if (ram_we) vote_mem[ram_waddr] <= it_vote_ff;
      if (ram_re) ram_q_ff <= vote_mem[ram_raddr];
   end

   // an entry never written reads as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         vt_valid_ff <= '0;
      end else if (ram_we) begin
         vt_valid_ff[ram_waddr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ram_re) rd_valid_ff <= vt_valid_ff[ram_raddr];
   end

   // -------------------------------------------------------- item capture
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         it_func_ff <= req_tuser;
         it_pol_ff  <= req_tdata[2:0];
         it_gov_ff  <= req_tdata[5:3];
         it_vote_ff <= req_tdata[37:6];
         it_vrel_ff <= req_tdata[38];
         it_mode_ff <= req_tdata[40:39];
         it_lo_ff   <= req_tdata[72:41];
         it_hi_ff   <= req_tdata[104:73];
      end
   end

   // ------------------------------------------------ policy state and csr
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_gov_ff <= NGOV_W'(2);
         for (int p = 0; p < NUM_POLICIES; p++) begin
            pol_mode_ff[p] <= MODE_MAX;
            pol_lo_ff[p]   <= '0;
            pol_hi_ff[p]   <= '1;
         end
      end else begin
         if (csr_valid) begin
            if (csr_index == CSR_NUM_GOV) begin
               num_gov_ff <= csr_data;
            end else if ((csr_index == CSR_DEF_MODE) && (csr_data[1:0] != MODE_BAD)) begin
               for (int p = 0; p < NUM_POLICIES; p++) begin
                  pol_mode_ff[p] <= csr_data[1:0];
               end
            end
         end
         if ((state_ff == ST_APPLY) && pol_ok) begin
            if ((it_func_ff == FUNC_MODE) && !mode_bad) begin
               pol_mode_ff[it_pol_ff] <= it_mode_ff;
            end
            if (it_func_ff == FUNC_LIMITS) begin
               pol_lo_ff[it_pol_ff] <= it_lo_ff;
               pol_hi_ff[it_pol_ff] <= it_hi_ff;
            end
         end
      end
   end

   // ------------------------------------------------------ scan and divide
   assign vote_rd = rd_valid_ff ? ram_q_ff : '0;
   assign acc_lo  = acc_ff[FREQ_W-1:0];
   assign div_sh  = {rem_ff, div_q_ff[SUM_W-1]};
   assign div_ge  = div_sh >= {1'b0, gov_cnt};

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else begin
         pend_ff <= scan_issue;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_APPLY: begin
            issue_ff    <= '0;
            cur_mode_ff <= eff_mode;
            acc_ff      <= (eff_mode == MODE_MIN) ? SUM_W'({FREQ_W{1'b1}}) : '0;
         end
         ST_SCAN: begin
            if (scan_issue) issue_ff <= issue_ff + 1'b1;
            if (pend_ff) begin
               case (cur_mode_ff)
                  MODE_MAX: if (vote_rd > acc_lo) acc_ff <= SUM_W'(vote_rd);
                  MODE_MIN: if (vote_rd < acc_lo) acc_ff <= SUM_W'(vote_rd);
                  default:  acc_ff <= acc_ff + SUM_W'(vote_rd);
               endcase
            end
            div_q_ff   <= acc_ff;
            rem_ff     <= '0;
            div_cnt_ff <= '0;
         end
         ST_DIV: begin
            // restoring divide, one quotient bit per cycle
            div_q_ff   <= {div_q_ff[SUM_W-2:0], div_ge};
            rem_ff     <= div_ge ? GOV_CNT_W'(div_sh - {1'b0, gov_cnt})
                                 : GOV_CNT_W'(div_sh);
            div_cnt_ff <= div_cnt_ff + 1'b1;
         end
         default: begin
            issue_ff <= issue_ff;
         end
      endcase
   end

   // --------------------------------------------------------------- result
   assign comb_t   = ((cur_mode_ff == MODE_AVG) && (gov_cnt != '0))
                     ? div_q_ff[FREQ_W-1:0] : acc_lo;
   assign clamp_hi = (comb_t > pol_hi_ff[it_pol_ff]) ? pol_hi_ff[it_pol_ff] : comb_t;
   assign clamp_t  = (clamp_hi < pol_lo_ff[it_pol_ff]) ? pol_lo_ff[it_pol_ff] : clamp_hi;

   always_comb begin
      res_target = '0;
      res_rel    = 1'b0;
      res_pass   = 1'b0;
      res_err    = 1'b0;
      if (!pol_ok) begin
         res_target = '0;
      end else if ((it_func_ff == FUNC_VOTE) && !gov_known) begin
         res_target = it_vote_ff;
         res_rel    = it_vrel_ff;
         res_pass   = 1'b1;
      end else if ((it_func_ff == FUNC_MODE) && mode_bad) begin
         res_err = 1'b1;
      end else begin
         res_target = clamp_t;
         res_rel    = cur_mode_ff == MODE_MIN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_pol_ff    <= it_pol_ff;
         rsp_target_ff <= res_target;
         rsp_rel_ff    <= res_rel;
         rsp_pass_ff   <= res_pass;
         rsp_err_ff    <= res_err;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_rel_ff, rsp_target_ff, rsp_pol_ff};
   assign rsp_tuser  = {rsp_err_ff, rsp_pass_ff};

   // ----------------------------------------------------------- assertions
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> state_ff == ST_APPLY)
      else $error("accepted beat did not start processing");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser[0] && rsp_tuser[1]))
      else $error("pass-through and error flagged together");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> issue_ff <= gov_cnt)
      else $error("scan read past the enabled governors");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> !rsp_valid_ff || rsp_tready)
      else $error("result register overwritten before taken");

endmodule
`default_nettype wire

### tb/sv/fvc_tb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fvc_tb_pkg
// Target tracking for the frequency vote combiner testbench: keeps its own
// copy of the vote table, modes, limits and registers, works out the target
// of every accepted item and checks each result beat against it in order.
// ----------------------------------------------------------------------------
package fvc_tb_pkg;

   import fvc_pkg::*;

   // codes the block leaves without a name
   localparam logic [FUNC_W-1:0]    FUNC_SPARE  = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE2  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE3  = 2'd3;

   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      logic [POL_W-1:0]  policy;
      logic [FREQ_W-1:0] target;
      logic              relation;
      logic              passed;
      logic              error;
   } policy_target_type;

   class vote_ledger;
      logic [FREQ_W-1:0] votes [MAX_GOVERNORS][NUM_POLICIES];
      logic [MODE_W-1:0] modes [NUM_POLICIES];
      logic [FREQ_W-1:0] lows  [NUM_POLICIES];
      logic [FREQ_W-1:0] highs [NUM_POLICIES];
      logic [NGOV_W-1:0] gov_count;
      logic [MODE_W-1:0] def_mode;
      policy_target_type pending_targets[$];
      int                failures;

      function new();
         gov_count = 4'd2;
         def_mode  = MODE_MAX;
         failures  = 0;
         for (int p = 0; p < NUM_POLICIES; p++) begin
            modes[p] = MODE_MAX;
            lows[p]  = '0;
            highs[p] = '1;
            for (int g = 0; g < MAX_GOVERNORS; g++)
               votes[g][p] = '0;
         end
      endfunction

      function void note_failure(string msg);
         failures++;
         if (failures <= MAX_REPORTS)
            $display("%s", msg);
      endfunction

      function int enabled_governors();
         return (gov_count < MAX_GOVERNORS) ? int'(gov_count) : MAX_GOVERNORS;
      endfunction

      function void apply_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         if (idx == CSR_NUM_GOV) begin
            gov_count = data;
         end else if (idx == CSR_DEF_MODE && data[1:0] != MODE_BAD) begin
            def_mode = data[1:0];
            for (int p = 0; p < NUM_POLICIES; p++)
               modes[p] = data[1:0];
         end
      endfunction

      function logic [FREQ_W-1:0] combine_policy(int pol, output logic rel);
         int                n;
         logic [MODE_W-1:0] mode;
         logic [FREQ_W-1:0] t;
         logic [63:0]       sum;
         n    = enabled_governors();
         mode = modes[pol];
         t    = (mode == MODE_MIN) ? '1 : '0;
         sum  = '0;
         for (int g = 0; g < n; g++) begin
            if (mode == MODE_MAX) begin
               if (votes[g][pol] > t) t = votes[g][pol];
            end else if (mode == MODE_MIN) begin
               if (votes[g][pol] < t) t = votes[g][pol];
            end else begin
               sum += 64'(votes[g][pol]);
            end
         end
         if (mode == MODE_AVG && n != 0)
            t = 32'(sum / 64'(n));
         rel = (mode == MODE_MIN);
         // high limit first, so the low limit wins when they cross
         if (t > highs[pol]) t = highs[pol];
         if (t < lows[pol])  t = lows[pol];
         return t;
      endfunction

      function void record_item(logic [FUNC_W-1:0] func, logic [REQ_DATA_W-1:0] data);
         policy_target_type e;
         int                pol;
         int                gov;
         logic              rel;
         pol = int'(data[2:0]);
         gov = int'(data[5:3]);
         e   = '0;
         rel = 1'b0;
         e.policy = data[2:0];
         case (func)
            FUNC_VOTE: begin
               if (gov < enabled_governors()) begin
                  votes[gov][pol] = data[37:6];
                  e.target = combine_policy(pol, rel);
                  e.relation = rel;
               end else begin
                  e.target   = data[37:6];
                  e.relation = data[38];
                  e.passed   = 1'b1;
               end
            end
            FUNC_MODE: begin
               if (data[40:39] == MODE_BAD) begin
                  e.error = 1'b1;
               end else begin
                  modes[pol] = data[40:39];
                  e.target = combine_policy(pol, rel);
                  e.relation = rel;
               end
            end
            FUNC_LIMITS: begin
               lows[pol]  = data[72:41];
               highs[pol] = data[104:73];
               e.target = combine_policy(pol, rel);
               e.relation = rel;
            end
            default: begin
               e.target = combine_policy(pol, rel);
               e.relation = rel;
            end
         endcase
         pending_targets.push_back(e);
      endfunction

      function void compare_target(logic [RSP_DATA_W-1:0] data, logic [1:0] user);
         policy_target_type e;
         policy_target_type got;
         got.policy   = data[2:0];
         got.target   = data[34:3];
         got.relation = data[35];
         got.passed   = user[0];
         got.error    = user[1];
         if (pending_targets.size() == 0) begin
            note_failure($sformatf({"unexpected result beat: policy %0d target %h ",
               "rel %0d pass %0d err %0d"},
               got.policy, got.target, got.relation, got.passed, got.error));
            return;
         end
         e = pending_targets.pop_front();
         if (got.policy !== e.policy || got.target !== e.target ||
             got.relation !== e.relation || got.passed !== e.passed ||
             got.error !== e.error)
            note_failure($sformatf({"result mismatch: expected policy %0d target %h rel %0d ",
               "pass %0d err %0d, got policy %0d target %h rel %0d pass %0d err %0d"},
               e.policy, e.target, e.relation, e.passed, e.error,
               got.policy, got.target, got.relation, got.passed, got.error));
      endfunction
   endclass

endpackage
`default_nettype wire

### tb/sv/testbench.sv
`default_nettype none
// ----------------------------------------------------------------------------
// testbench
// Drives vote, mode, limit and spare items into the frequency vote combiner
// under several governor counts and default modes, with random gaps on the
// request side and random stalls on the response side, and checks every
// result beat against a target computed alongside.
// ----------------------------------------------------------------------------
module testbench;

   import fvc_pkg::*;
   import fvc_tb_pkg::*;

   localparam int NUM_PHASES  = 8;
   localparam int PHASE_ITEMS = 195;
   localparam int TAIL_CYCLES = 60;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [FUNC_W-1:0]     req_tuser = FUNC_VOTE;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b1;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [1:0]            rsp_tuser;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_NUM_GOV;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   int         send_idle_pct = 0;
   int         rsp_stall_pct = 0;
   vote_ledger ledger = new();

   frequency_vote_combiner dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready)
            ledger.apply_csr(csr_index, csr_data);
         if (req_tvalid && req_tready)
            ledger.record_item(req_tuser, req_tdata);
         if (rsp_tvalid && rsp_tready)
            ledger.compare_target(rsp_tdata, rsp_tuser);
      end
   end

   initial begin
      #10_000_000;
      $display("tb: failure");
      $finish;
   end

   function automatic logic [REQ_DATA_W-1:0] pack_req(
      logic [POL_W-1:0] pol, logic [GOV_W-1:0] gov, logic [FREQ_W-1:0] vote,
      logic vrel, logic [MODE_W-1:0] mode, logic [FREQ_W-1:0] lo, logic [FREQ_W-1:0] hi);
      return {7'd0, hi, lo, mode, vrel, vote, gov, pol};
   endfunction

   function automatic logic [FREQ_W-1:0] pick_freq();
      case ($urandom_range(5))
         0:       return '0;
         1:       return '1;
         2, 3:    return $urandom;
         default: return $urandom_range(3_000_000, 200_000);
      endcase
   endfunction

   // called at a falling edge, returns at a falling edge
   task automatic send_item(logic [FUNC_W-1:0] func, logic [REQ_DATA_W-1:0] data);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = func;
      req_tdata  = data;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic wait_drained();
      while (ledger.pending_targets.size() != 0)
         @(negedge clock);
   endtask

   task automatic send_random_item();
      logic [FUNC_W-1:0] func;
      logic [POL_W-1:0]  pol;
      logic [GOV_W-1:0]  gov;
      logic [FREQ_W-1:0] vote;
      logic [FREQ_W-1:0] lo;
      logic [FREQ_W-1:0] hi;
      int                r;
      int                n;
      r    = $urandom_range(99);
      func = (r < 55) ? FUNC_VOTE : (r < 72) ? FUNC_MODE : (r < 92) ? FUNC_LIMITS : FUNC_SPARE;
      pol  = 3'($urandom);
      n    = ledger.enabled_governors();
      // mostly known governors so votes land in the table
      gov  = (n > 0 && $urandom_range(3) != 0) ? 3'($urandom_range(n - 1)) : 3'($urandom);
      vote = pick_freq();
      case ($urandom_range(4))
         0, 1: begin
            lo = '0;
            hi = '1;
         end
         2, 3: begin
            lo = $urandom_range(2_000_000);
            hi = lo + $urandom_range(2_000_000);
         end
         default: begin
            lo = $urandom;
            hi = $urandom;
         end
      endcase
      send_item(func, pack_req(pol, gov, vote, 1'($urandom), 2'($urandom), lo, hi));
   endtask

   initial begin
      logic [NGOV_W-1:0] phase_gov [NUM_PHASES];
      logic [MODE_W-1:0] phase_mode [NUM_PHASES];
      phase_gov  = '{4'd8, 4'd1, 4'd0, 4'd15, 4'd4, 4'd8, 4'd3, 4'd9};
      phase_mode = '{MODE_AVG, MODE_MIN, MODE_MAX, MODE_AVG, MODE_BAD, MODE_MIN, MODE_AVG, MODE_MAX};

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed items under the reset settings: two governors, max mode
      send_item(FUNC_VOTE,   pack_req(3'd0, 3'd0, '1, 1'b0, MODE_MAX, '0, '0));
      send_item(FUNC_VOTE,   pack_req(3'd0, 3'd1, '0, 1'b0, MODE_MAX, '0, '0));
      // unknown governors are forwarded with their relation
      send_item(FUNC_VOTE,   pack_req(3'd7, 3'd7, 32'h1234_5678, 1'b1, MODE_MAX, '0, '0));
      send_item(FUNC_VOTE,   pack_req(3'd3, 3'd2, '1, 1'b0, MODE_MAX, '0, '0));
      send_item(FUNC_MODE,   pack_req(3'd0, 3'd0, '0, 1'b0, MODE_MIN, '0, '0));
      send_item(FUNC_MODE,   pack_req(3'd0, 3'd0, '0, 1'b0, MODE_AVG, '0, '0));
      send_item(FUNC_MODE,   pack_req(3'd0, 3'd0, '0, 1'b0, MODE_BAD, '0, '0));
      send_item(FUNC_MODE,   pack_req(3'd0, 3'd0, '0, 1'b0, MODE_MAX, '0, '0));
      send_item(FUNC_LIMITS, pack_req(3'd0, 3'd0, '0, 1'b0, MODE_MAX, 32'h1000, 32'h2000));
      // crossed limits: low limit wins
      send_item(FUNC_LIMITS, pack_req(3'd0, 3'd0, '0, 1'b0, MODE_MAX, 32'h3000, 32'h2000));
      send_item(FUNC_LIMITS, pack_req(3'd0, 3'd0, '0, 1'b0, MODE_MAX, '0, '1));
      send_item(FUNC_SPARE,  pack_req(3'd0, 3'd0, '0, 1'b0, MODE_MAX, '0, '0));
      send_item(FUNC_SPARE,  pack_req(3'd6, 3'd5, '1, 1'b1, MODE_BAD, '1, '0));
      // average sum wider than 32 bits
      send_item(FUNC_VOTE,   pack_req(3'd7, 3'd1, '1, 1'b0, MODE_MAX, '0, '0));
      send_item(FUNC_VOTE,   pack_req(3'd7, 3'd0, 32'hFFFF_FFFE, 1'b0, MODE_MAX, '0, '0));
      send_item(FUNC_MODE,   pack_req(3'd7, 3'd0, '0, 1'b0, MODE_AVG, '0, '0));
      send_item(FUNC_MODE,   pack_req(3'd7, 3'd0, '0, 1'b0, MODE_MIN, '0, '0));
      send_item(FUNC_LIMITS, pack_req(3'd7, 3'd0, '0, 1'b0, MODE_MAX, '1, '1));
      send_item(FUNC_LIMITS, pack_req(3'd4, 3'd0, '0, 1'b0, MODE_MAX, '0, '0));
      send_item(FUNC_VOTE,   pack_req(3'd4, 3'd1, 32'd5, 1'b0, MODE_MAX, '0, '0));

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         // registers only change with nothing in flight
         wait_drained();
         csr_write(CSR_NUM_GOV, phase_gov[ph]);
         csr_write(CSR_DEF_MODE, {2'($urandom), phase_mode[ph]});
         if (ph == 4) begin
            csr_write(CSR_SPARE2, 4'($urandom));
            csr_write(CSR_SPARE3, 4'($urandom));
         end
         case (ph % 4)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 55; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 55; end
            default: begin send_idle_pct = 38; rsp_stall_pct = 38; end
         endcase
         for (int i = 0; i < PHASE_ITEMS; i++)
            send_random_item();
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (ledger.failures == 0 && ledger.pending_targets.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
`default_nettype wire
